>>> design/ntmp_pkg.sv
// Shared constants, types and codes of the nibble-table multi-pattern prefilter.
package ntmp_pkg;

    localparam int LANES       = 8;
    localparam int MAX_POS     = 4;
    localparam int OFFSET_BITS = 32;
    localparam int GROUPS      = 8;
    localparam int NIBBLES     = 16;
    localparam int CHUNK_W     = 32;

    localparam int HIST_DEPTH  = (MAX_POS > 1) ? (MAX_POS - 1) : 1;
    localparam int TAB_SELS    = 2 * MAX_POS;
    localparam int SEL_W       = (TAB_SELS > 1) ? $clog2(TAB_SELS) : 1;
    localparam int POS_W       = (MAX_POS > 1) ? $clog2(MAX_POS) : 1;
    localparam int CNT_W       = $clog2(LANES + 1);
    localparam int EXT_N       = HIST_DEPTH + LANES;
    localparam int EXT_W       = $clog2(EXT_N);

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic {
        MODE_TABLE = 1'b0,
        MODE_DATA  = 1'b1
    } t_mode;

    typedef enum logic {
        CFG_SIGMA  = 1'b0,
        CFG_GROUPS = 1'b1
    } t_cfg_idx;

    typedef logic [7:0] t_byte;
    typedef t_byte [MAX_POS-1:0] t_pos_vals;

    // Data item waiting between lookup and merge.
    typedef struct packed {
        logic             valid;
        logic             start;
        logic [CNT_W-1:0] cnt;
    } t_item_ctl;

    // Decoded configuration for the merge stage.
    typedef struct packed {
        logic [POS_W-1:0] sig_idx;
        t_byte            gmask;
    } t_cfg;

endpackage

>>> design/nibble_table_multi_pattern_prefilter.sv
// Top level of the nibble-table multi-pattern prefilter: ports, config, lookup lanes, merge.
//
// Input stream (i_s_*): i_s_tuser is the mode, 0 for a table write beat, 1 for a data
// beat. A table write updates one entry of the low- or high-nibble table of one
// pattern position and returns nothing. A data beat carries up to eight bytes and
// returns one beat on the output stream (o_m_*): a per-lane hit mask and the stream
// offset of lane zero.
// Configuration (i_cfg_*): index 0 sets the number of positions compared, index 1
// the number of enabled groups; write only while no data beat is in flight.
// Timing: a data beat is looked up into the lane registers when it is accepted and
// merged into the output register once the merge stage is free, which raises
// o_m_tvalid. Throughput: one beat per cycle in either mode while o_s_tready is
// high; the merge stage carries the byte history from one beat to the next.
// Reset: history reads as 0xFF, offset zero, sigma one, eight groups. Table
// contents are not cleared and must be written before use.
// Stall: with the output held, one more beat is taken into the lookup stage; then
// o_s_tready drops until the receiver takes the pending result.
module nibble_table_multi_pattern_prefilter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [2:0] table_select, [6:3] table_index, [14:7] table_value, [78:15] data_bytes,
    // [82:79] byte_count, [83] stream_start, [87:84] zero
    input  logic [ntmp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // [0] mode
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [7:0] per-lane hit flags, [39:8] chunk_offset
    output logic [ntmp_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                i_cfg_wr_en,
    input  logic [0:0]                          i_cfg_index,
    input  logic [3:0]                          i_cfg_data
);

    logic [2:0]                 r_sigma;
    logic [3:0]                 r_groups;
    logic                       r_a_valid;
    logic                       r_a_start;
    logic [ntmp_pkg::CNT_W-1:0] r_a_cnt;
    logic [ntmp_pkg::CNT_W-1:0] cnt_sat;
    logic [3:0]                 groups_sat;
    logic                       accept;
    logic                       is_data;
    logic                       tab_wr;
    logic                       merge_free;
    logic [ntmp_pkg::LANES-1:0] hits;
    logic [ntmp_pkg::CHUNK_W-1:0] chunk;

    ntmp_pkg::t_item_ctl a_ctl;
    ntmp_pkg::t_cfg      cfg;
    ntmp_pkg::t_pos_vals lane_vals [ntmp_pkg::LANES];

    assign is_data    = (i_s_tuser == ntmp_pkg::MODE_DATA);
    assign o_s_tready = !r_a_valid || merge_free;
    assign accept     = i_s_tvalid && o_s_tready;
    // Drop writes to positions the block does not have.
    assign tab_wr     = accept && !is_data && (int'(i_s_tdata[2:0]) < ntmp_pkg::TAB_SELS);

    assign cnt_sat = (int'(i_s_tdata[82:79]) > ntmp_pkg::LANES) ?
                     ntmp_pkg::CNT_W'(ntmp_pkg::LANES) : ntmp_pkg::CNT_W'(i_s_tdata[82:79]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma  <= 3'd1;
            r_groups <= 4'd8;
        end else if (i_cfg_wr_en) begin
            unique case (ntmp_pkg::t_cfg_idx'(i_cfg_index))
                ntmp_pkg::CFG_SIGMA:  r_sigma  <= i_cfg_data[2:0];
                ntmp_pkg::CFG_GROUPS: r_groups <= i_cfg_data;
                default:              r_groups <= r_groups;
            endcase
        end
    end

    // Saturate sigma to 1..MAX_POS and groups to 0..8.
    always_comb begin
        priority if (r_sigma == 3'd0) begin
            cfg.sig_idx = '0;
        end else if (int'(r_sigma) > ntmp_pkg::MAX_POS) begin
            cfg.sig_idx = ntmp_pkg::POS_W'(ntmp_pkg::MAX_POS - 1);
        end else begin
            cfg.sig_idx = ntmp_pkg::POS_W'(r_sigma - 3'd1);
        end
        groups_sat = (int'(r_groups) > ntmp_pkg::GROUPS) ? 4'(ntmp_pkg::GROUPS) : r_groups;
        cfg.gmask  = ~(8'hFF << groups_sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept && is_data) begin
            r_a_valid <= 1'b1;
        end else if (merge_free) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && is_data) begin
            r_a_start <= i_s_tdata[83];
            r_a_cnt   <= cnt_sat;
        end
    end

    assign a_ctl.valid = r_a_valid;
    assign a_ctl.start = r_a_start;
    assign a_ctl.cnt   = r_a_cnt;

    for (genvar k = 0; k < ntmp_pkg::LANES; k++) begin : g_lane
        ntmp_lane u_lane (
            .i_clk      (i_clk),
            .i_wr_en    (tab_wr),
            .i_wr_sel   (i_s_tdata[ntmp_pkg::SEL_W-1:0]),
            .i_wr_index (i_s_tdata[6:3]),
            .i_wr_value (i_s_tdata[14:7]),
            .i_load     (accept && is_data),
            .i_byte     (i_s_tdata[15+8*k +: 8]),
            .o_vals     (lane_vals[k])
        );
    end

    ntmp_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (a_ctl),
        .i_cfg    (cfg),
        .i_vals   (lane_vals),
        .i_ready  (i_m_tready),
        .o_free   (merge_free),
        .o_valid  (o_m_tvalid),
        .o_hits   (hits),
        .o_offset (chunk)
    );

    assign o_m_tdata = {chunk, hits};

endmodule

>>> design/ntmp_lane.sv
// One byte lane: private copy of the nibble tables and per-position lookup.
module ntmp_lane (
    input  logic                            i_clk,
    input  logic                            i_wr_en,
    input  logic [ntmp_pkg::SEL_W-1:0]      i_wr_sel,
    input  logic [3:0]                      i_wr_index,
    input  ntmp_pkg::t_byte                 i_wr_value,
    input  logic                            i_load,
    input  ntmp_pkg::t_byte                 i_byte,
    output ntmp_pkg::t_pos_vals             o_vals
);

    ntmp_pkg::t_byte     r_tab [ntmp_pkg::TAB_SELS][ntmp_pkg::NIBBLES];
    ntmp_pkg::t_pos_vals r_vals;
    ntmp_pkg::t_pos_vals n_vals;

    // Even table of a position holds the low nibble, odd one the high nibble.
    for (genvar p = 0; p < ntmp_pkg::MAX_POS; p++) begin : g_pos
        assign n_vals[p] = r_tab[2*p][i_byte[3:0]] | r_tab[2*p+1][i_byte[7:4]];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_tab[i_wr_sel][i_wr_index] <= i_wr_value;
        end
        if (i_load) begin
            r_vals <= n_vals;
        end
    end

    assign o_vals = r_vals;

endmodule

>>> design/ntmp_merge.sv
// Merge stage: combines lane values with stream history, forms hit mask and offset.
module ntmp_merge (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ntmp_pkg::t_item_ctl       i_ctl,
    input  ntmp_pkg::t_cfg            i_cfg,
    input  ntmp_pkg::t_pos_vals       i_vals [ntmp_pkg::LANES],
    input  logic                      i_ready,
    output logic                      o_free,
    output logic                      o_valid,
    output logic [ntmp_pkg::LANES-1:0] o_hits,
    output logic [ntmp_pkg::CHUNK_W-1:0] o_offset
);

    ntmp_pkg::t_byte r_hist [ntmp_pkg::MAX_POS][ntmp_pkg::HIST_DEPTH];
    ntmp_pkg::t_byte n_hist [ntmp_pkg::MAX_POS][ntmp_pkg::HIST_DEPTH];
    ntmp_pkg::t_byte ext    [ntmp_pkg::MAX_POS][ntmp_pkg::EXT_N];
    ntmp_pkg::t_byte acc_s  [ntmp_pkg::LANES][ntmp_pkg::MAX_POS];
    ntmp_pkg::t_byte acc    [ntmp_pkg::LANES];

    logic [ntmp_pkg::OFFSET_BITS-1:0] r_off;
    logic [ntmp_pkg::OFFSET_BITS-1:0] base;
    logic [ntmp_pkg::OFFSET_BITS-1:0] n_off;
    logic [ntmp_pkg::LANES-1:0]       n_hits;
    logic [ntmp_pkg::LANES-1:0]       r_hits;
    logic [ntmp_pkg::CHUNK_W-1:0]     r_chunk;
    logic                             r_out_valid;
    logic                             load;

    assign o_free = !r_out_valid || i_ready;
    assign load   = i_ctl.valid && o_free;

    // Oldest history first, then this beat's lanes in stream order.
    always_comb begin
        for (int p = 0; p < ntmp_pkg::MAX_POS; p++) begin
            for (int j = 0; j < ntmp_pkg::HIST_DEPTH; j++) begin
                ext[p][ntmp_pkg::HIST_DEPTH-1-j] = i_ctl.start ? 8'hFF : r_hist[p][j];
            end
            for (int k = 0; k < ntmp_pkg::LANES; k++) begin
                ext[p][ntmp_pkg::HIST_DEPTH+k] = i_vals[k][p];
            end
        end
    end

    // Candidate OR for every sigma; position p looks back (sigma-1-p) bytes.
    always_comb begin
        for (int k = 0; k < ntmp_pkg::LANES; k++) begin
            for (int s = 0; s < ntmp_pkg::MAX_POS; s++) begin
                acc_s[k][s] = i_vals[k][s];
                for (int p = 0; p < s; p++) begin
                    acc_s[k][s] = acc_s[k][s] | ext[p][ntmp_pkg::HIST_DEPTH+k-s+p];
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < ntmp_pkg::LANES; k++) begin
            acc[k]    = acc_s[k][i_cfg.sig_idx];
            n_hits[k] = (ntmp_pkg::CNT_W'(k) < i_ctl.cnt) && (|(~acc[k] & i_cfg.gmask));
        end
    end

    // Shift the valid lanes into history; newest byte lands in slot zero.
    always_comb begin
        for (int p = 0; p < ntmp_pkg::MAX_POS; p++) begin
            for (int j = 0; j < ntmp_pkg::HIST_DEPTH; j++) begin
                n_hist[p][j] = ext[p][ntmp_pkg::EXT_W'(ntmp_pkg::HIST_DEPTH-1-j)
                                      + ntmp_pkg::EXT_W'(i_ctl.cnt)];
            end
        end
    end

    assign base  = i_ctl.start ? '0 : r_off;
    assign n_off = base + ntmp_pkg::OFFSET_BITS'(i_ctl.cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_off       <= '0;
            for (int p = 0; p < ntmp_pkg::MAX_POS; p++) begin
                for (int j = 0; j < ntmp_pkg::HIST_DEPTH; j++) begin
                    r_hist[p][j] <= 8'hFF;
                end
            end
        end else if (load) begin
            r_out_valid <= 1'b1;
            r_off       <= n_off;
            r_hist      <= n_hist;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hits  <= n_hits;
            r_chunk <= ntmp_pkg::CHUNK_W'(base);
        end
    end

    assign o_valid  = r_out_valid;
    assign o_hits   = r_hits;
    assign o_offset = r_chunk;

    a_offset_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !i_ctl.start) |=> (r_off == $past(r_off + ntmp_pkg::OFFSET_BITS'(i_ctl.cnt))))
        else $error("byte offset did not advance by the lane count");

    a_empty_no_hits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_ctl.cnt == '0) |=> (r_hits == '0))
        else $error("hit reported on a beat without valid lanes");

    a_start_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && i_ctl.start && i_ctl.cnt == '0) |=>
        (r_hist[0][0] == 8'hFF && r_off == '0))
        else $error("stream start did not clear history and offset");

endmodule
